// ===== rtl/assert_macros.svh =====
// assert_macros.svh: shorthand macros for concurrent assertions
// used by the wipe blend top level, no other dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(name, clock, resetn, cond, expr) \
    name: assert property (@(posedge clock) disable iff (!resetn) (cond) |-> (expr)) \
        else $error("same-cycle check failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(name, clock, resetn, cond, expr) \
    name: assert property (@(posedge clock) disable iff (!resetn) (cond) |=> (expr)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/dsw_pkg.sv =====
// dsw_pkg: shared codes, constants and types of the directional wipe blend
// no dependencies
package dsw_pkg;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPEED        = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DIR_X        = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DIR_Y        = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DIR_Z        = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_START        = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_END          = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_RECIP = 3'd6;

    localparam int SPEED_BITS = 16;
    localparam int DELTA_BITS = 16;
    localparam int DIR_BITS   = 16;
    localparam int RECIP_BITS = 24;
    localparam int INC_BITS   = 24;
    localparam int TIME_BITS  = 17;
    localparam int DIFF_BITS  = 40;
    localparam int FPROD_BITS = 64;

    localparam logic [TIME_BITS-1:0] ONE_Q16 = 17'd65536;
    localparam logic signed [DIFF_BITS-1:0] DIFF_LIMIT = 40'sh40_0000_0000;

    localparam logic [SPEED_BITS-1:0] SPEED_RST = 16'd51;
    localparam logic signed [DIR_BITS-1:0] DIR_X_RST = 16'sd32767;
    localparam logic signed [DIR_BITS-1:0] DIR_Y_RST = 16'sd0;
    localparam logic signed [DIR_BITS-1:0] DIR_Z_RST = 16'sd0;
    localparam logic signed [63:0] START_RST = -64'sd6553600;
    localparam logic signed [63:0] END_RST   = 64'sd6553600;
    localparam logic [RECIP_BITS-1:0] RECIP_RST = 24'd16384;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== rtl/dsw_queue.sv =====
// dsw_queue: small register fifo between the front and back parts
// depends on dsw_pkg for the status struct
module dsw_queue #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [WIDTH-1:0]    push_data,
    input  logic                pop,
    output logic [WIDTH-1:0]    pop_data,
    output dsw_pkg::q_status_t  status
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == (AW+1)'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/dsw_front.sv =====
// dsw_front: accepts items, forms tick increment and projected distance
// depends on dsw_pkg; feeds dsw_queue
module dsw_front #(
    parameter int POSITION_BITS = 32,
    parameter int COLOR_BITS    = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   operation,
    input  logic [dsw_pkg::DELTA_BITS-1:0]         frame_delta,
    input  logic signed [POSITION_BITS-1:0]        pos_x,
    input  logic signed [POSITION_BITS-1:0]        pos_y,
    input  logic signed [POSITION_BITS-1:0]        pos_z,
    input  logic [COLOR_BITS-1:0]                  new_red,
    input  logic [COLOR_BITS-1:0]                  new_green,
    input  logic [COLOR_BITS-1:0]                  new_blue,
    input  logic [COLOR_BITS-1:0]                  old_red,
    input  logic [COLOR_BITS-1:0]                  old_green,
    input  logic [COLOR_BITS-1:0]                  old_blue,
    input  logic [dsw_pkg::SPEED_BITS-1:0]         speed,
    input  logic signed [dsw_pkg::DIR_BITS-1:0]    dir_x,
    input  logic signed [dsw_pkg::DIR_BITS-1:0]    dir_y,
    input  logic signed [dsw_pkg::DIR_BITS-1:0]    dir_z,
    input  dsw_pkg::q_status_t                     q_status,
    output logic                                   push,
    output logic [1+dsw_pkg::INC_BITS+POSITION_BITS+3+6*COLOR_BITS-1:0] push_data
);

    localparam int PROD_BITS = POSITION_BITS + dsw_pkg::DIR_BITS;
    localparam int DIST_BITS = POSITION_BITS + 3;
    localparam int DMUL_BITS = 2 * dsw_pkg::DELTA_BITS;

    logic                          valid_reg;
    logic                          op_reg;
    logic [dsw_pkg::INC_BITS-1:0]  inc_reg;
    logic signed [PROD_BITS-1:0]   prod_x_reg;
    logic signed [PROD_BITS-1:0]   prod_y_reg;
    logic signed [PROD_BITS-1:0]   prod_z_reg;
    logic [6*COLOR_BITS-1:0]       color_reg;
    logic                          accept;
    logic [DMUL_BITS-1:0]          delta_prod;
    logic signed [PROD_BITS-1:0]   sh_x;
    logic signed [PROD_BITS-1:0]   sh_y;
    logic signed [PROD_BITS-1:0]   sh_z;
    logic signed [DIST_BITS-1:0]   proj_dist;

    assign in_stall   = valid_reg && q_status.full;
    assign accept     = in_valid && !in_stall;
    assign push       = valid_reg && !q_status.full;
    assign delta_prod = DMUL_BITS'(frame_delta) * DMUL_BITS'(speed);

    // floor shift of each q16.16 x q1.15 product back to q16.16
    assign sh_x = prod_x_reg >>> 15;
    assign sh_y = prod_y_reg >>> 15;
    assign sh_z = prod_z_reg >>> 15;
    assign proj_dist = DIST_BITS'(sh_x) + DIST_BITS'(sh_y) + DIST_BITS'(sh_z);

    assign push_data = {op_reg, inc_reg, proj_dist, color_reg};

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= operation;
            inc_reg    <= dsw_pkg::INC_BITS'(delta_prod >> 8);
            prod_x_reg <= pos_x * dir_x;
            prod_y_reg <= pos_y * dir_y;
            prod_z_reg <= pos_z * dir_z;
            color_reg  <= {new_red, new_green, new_blue, old_red, old_green, old_blue};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (push)
        begin
            valid_reg <= 1'b0;
        end
    end

endmodule

// ===== rtl/dsw_back.sv =====
// dsw_back: sequencer that runs ticks and pixel blends one at a time
// depends on dsw_pkg; drains dsw_queue and drives the result register
module dsw_back #(
    parameter int POSITION_BITS = 32,
    parameter int COLOR_BITS    = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  dsw_pkg::q_status_t                     q_status,
    output logic                                   pop,
    input  logic [1+dsw_pkg::INC_BITS+POSITION_BITS+3+6*COLOR_BITS-1:0] pop_data,
    input  logic signed [POSITION_BITS-1:0]        start_position,
    input  logic signed [POSITION_BITS-1:0]        end_position,
    input  logic [dsw_pkg::RECIP_BITS-1:0]         window_recip,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [COLOR_BITS-1:0]                  out_red,
    output logic [COLOR_BITS-1:0]                  out_green,
    output logic [COLOR_BITS-1:0]                  out_blue,
    output logic                                   wipe_done,
    output logic                                   tick_reply
);

    localparam int DIST_BITS = POSITION_BITS + 3;
    localparam int DW        = (POSITION_BITS + 4 > dsw_pkg::DIFF_BITS) ?
                               POSITION_BITS + 4 : dsw_pkg::DIFF_BITS;
    localparam int PW        = POSITION_BITS + 18;
    localparam int SW        = POSITION_BITS + 19;
    localparam int TW        = dsw_pkg::INC_BITS + 1;
    localparam int MW        = COLOR_BITS + 17;
    localparam int TB        = dsw_pkg::TIME_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TMUL = 3'd1;
    localparam logic [2:0] S_TSUM = 3'd2;
    localparam logic [2:0] S_PMUL = 3'd3;
    localparam logic [2:0] S_PFAC = 3'd4;
    localparam logic [2:0] S_PMIX = 3'd5;

    logic [2:0]                            state_reg;
    logic [TB-1:0]                         anim_reg;
    logic signed [POSITION_BITS-1:0]       wipe_reg;
    logic signed [dsw_pkg::DIFF_BITS-1:0]  diff_reg;
    logic signed [PW-1:0]                  prod_a_reg;
    logic signed [PW-1:0]                  prod_b_reg;
    logic signed [dsw_pkg::FPROD_BITS-1:0] prodf_reg;
    logic [TB-1:0]                         f_reg;
    logic [3*COLOR_BITS-1:0]               new_reg;
    logic [3*COLOR_BITS-1:0]               old_reg;
    logic                                  out_valid_reg;
    logic [COLOR_BITS-1:0]                 out_red_reg;
    logic [COLOR_BITS-1:0]                 out_green_reg;
    logic [COLOR_BITS-1:0]                 out_blue_reg;
    logic                                  out_done_reg;
    logic                                  out_tick_reg;

    logic                                  h_op;
    logic [dsw_pkg::INC_BITS-1:0]          h_inc;
    logic signed [DIST_BITS-1:0]           h_dist;
    logic [3*COLOR_BITS-1:0]               h_new;
    logic [3*COLOR_BITS-1:0]               h_old;
    logic [TW-1:0]                         t_sum;
    logic [TB-1:0]                         anim_sat;
    logic signed [DW-1:0]                  diff_w;
    logic signed [DW-1:0]                  diff_c;
    logic signed [17:0]                    wt_start;
    logic signed [17:0]                    wt_end;
    logic signed [SW-1:0]                  wsum;
    logic signed [SW-1:0]                  wsum_sh;
    logic signed [dsw_pkg::FPROD_BITS-1:0] fsh;
    logic [TB-1:0]                         f_clamp;
    logic                                  out_free;
    logic                                  out_fire;
    logic                                  out_load;

    function automatic logic [COLOR_BITS-1:0] blend(
        input logic [COLOR_BITS-1:0] n,
        input logic [COLOR_BITS-1:0] o,
        input logic [TB-1:0]         f
    );
        logic [MW-1:0] acc;
        acc = MW'(n) * MW'(f) + MW'(o) * MW'(dsw_pkg::ONE_Q16 - f);
        return COLOR_BITS'(acc >> 16);
    endfunction

    assign {h_op, h_inc, h_dist, h_new, h_old} = pop_data;

    assign pop      = (state_reg == S_IDLE) && !q_status.empty;
    assign out_fire = out_valid_reg && !out_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = (state_reg inside {S_TSUM, S_PMIX}) && out_free;

    // time advance, saturating at one
    assign t_sum    = TW'(anim_reg) + TW'(h_inc);
    assign anim_sat = (t_sum > TW'(dsw_pkg::ONE_Q16)) ? dsw_pkg::ONE_Q16 : TB'(t_sum);

    // distance to the wipe edge, limited before the factor multiply
    assign diff_w = DW'(h_dist) - DW'(wipe_reg);
    always_comb
    begin
        if (diff_w > DW'(dsw_pkg::DIFF_LIMIT))
        begin
            diff_c = DW'(dsw_pkg::DIFF_LIMIT);
        end
        else if (diff_w < -DW'(dsw_pkg::DIFF_LIMIT))
        begin
            diff_c = -DW'(dsw_pkg::DIFF_LIMIT);
        end
        else
        begin
            diff_c = diff_w;
        end
    end

    assign wt_start = $signed({1'b0, dsw_pkg::ONE_Q16 - anim_reg});
    assign wt_end   = $signed({1'b0, anim_reg});
    assign wsum     = SW'(prod_a_reg) + SW'(prod_b_reg);
    assign wsum_sh  = wsum >>> 16;

    assign fsh = prodf_reg >>> 16;
    always_comb
    begin
        if (fsh < 0)
        begin
            f_clamp = '0;
        end
        else if (fsh > dsw_pkg::FPROD_BITS'(dsw_pkg::ONE_Q16))
        begin
            f_clamp = dsw_pkg::ONE_Q16;
        end
        else
        begin
            f_clamp = TB'(fsh);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                diff_reg <= dsw_pkg::DIFF_BITS'(diff_c);
                new_reg  <= h_new;
                old_reg  <= h_old;
            end
            S_TMUL:
            begin
                prod_a_reg <= start_position * wt_start;
                prod_b_reg <= end_position * wt_end;
            end
            S_PMUL:
            begin
                prodf_reg <= diff_reg * $signed({1'b0, window_recip});
            end
            S_PFAC:
            begin
                f_reg <= f_clamp;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            anim_reg      <= '0;
            wipe_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_red_reg   <= '0;
            out_green_reg <= '0;
            out_blue_reg  <= '0;
            out_done_reg  <= 1'b0;
            out_tick_reg  <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        if (h_op == dsw_pkg::OP_TICK)
                        begin
                            anim_reg  <= anim_sat;
                            state_reg <= S_TMUL;
                        end
                        else
                        begin
                            state_reg <= S_PMUL;
                        end
                    end
                end
                S_TMUL:
                begin
                    state_reg <= S_TSUM;
                end
                S_TSUM:
                begin
                    if (out_free)
                    begin
                        wipe_reg      <= POSITION_BITS'(wsum_sh);
                        out_red_reg   <= '0;
                        out_green_reg <= '0;
                        out_blue_reg  <= '0;
                        out_done_reg  <= anim_reg[TB-1];
                        out_tick_reg  <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_PMUL:
                begin
                    state_reg <= S_PFAC;
                end
                S_PFAC:
                begin
                    state_reg <= S_PMIX;
                end
                S_PMIX:
                begin
                    if (out_free)
                    begin
                        out_red_reg   <= blend(new_reg[3*COLOR_BITS-1:2*COLOR_BITS],
                                               old_reg[3*COLOR_BITS-1:2*COLOR_BITS], f_reg);
                        out_green_reg <= blend(new_reg[2*COLOR_BITS-1:COLOR_BITS],
                                               old_reg[2*COLOR_BITS-1:COLOR_BITS], f_reg);
                        out_blue_reg  <= blend(new_reg[COLOR_BITS-1:0],
                                               old_reg[COLOR_BITS-1:0], f_reg);
                        out_done_reg  <= anim_reg[TB-1];
                        out_tick_reg  <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_red    = out_red_reg;
    assign out_green  = out_green_reg;
    assign out_blue   = out_blue_reg;
    assign wipe_done  = out_done_reg;
    assign tick_reply = out_tick_reg;

endmodule

// ===== rtl/directional_soft_wipe_blend.sv =====
// directional_soft_wipe_blend: top level, configuration registers and assertions
// depends on dsw_pkg, dsw_front, dsw_queue, dsw_back and assert_macros.svh
//
// usage:
// items enter on in_valid/in_stall; operation selects a pixel blend or a
// frame tick. every item gives exactly one result on out_valid/out_stall,
// in order. ticks advance time by frame_delta * speed and move the wipe
// edge; pixels blend new over old by their distance past the edge.
// registers are written on cfg_valid/cfg_ready (ready is always high);
// the user must write them only while no item is in flight, as the block
// itself does not enforce it. the back sequencer runs each item through
// its multiply and blend states in turn, taking no new item until the
// last one is done.
// the front and a 2-entry queue keep accepting while the back works.
// a stalled result holds in the output register; the back waits on it,
// then the queue fills and in_stall rises.
// reset: registers take their defaults, time and wipe edge are zero.
`include "assert_macros.svh"

module directional_soft_wipe_blend #(
    parameter int POSITION_BITS = 32,
    parameter int COLOR_BITS    = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  operation,
    input  logic [dsw_pkg::DELTA_BITS-1:0]        frame_delta,
    input  logic signed [POSITION_BITS-1:0]       pos_x,
    input  logic signed [POSITION_BITS-1:0]       pos_y,
    input  logic signed [POSITION_BITS-1:0]       pos_z,
    input  logic [COLOR_BITS-1:0]                 new_red,
    input  logic [COLOR_BITS-1:0]                 new_green,
    input  logic [COLOR_BITS-1:0]                 new_blue,
    input  logic [COLOR_BITS-1:0]                 old_red,
    input  logic [COLOR_BITS-1:0]                 old_green,
    input  logic [COLOR_BITS-1:0]                 old_blue,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [COLOR_BITS-1:0]                 out_red,
    output logic [COLOR_BITS-1:0]                 out_green,
    output logic [COLOR_BITS-1:0]                 out_blue,
    output logic                                  wipe_done,
    output logic                                  tick_reply,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [dsw_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [((POSITION_BITS > dsw_pkg::RECIP_BITS) ?
                   POSITION_BITS : dsw_pkg::RECIP_BITS)-1:0] cfg_data
);

    localparam int EW = 1 + dsw_pkg::INC_BITS + POSITION_BITS + 3 + 6 * COLOR_BITS;
    localparam int QUEUE_DEPTH = 2;

    logic [dsw_pkg::SPEED_BITS-1:0]       speed_reg;
    logic signed [dsw_pkg::DIR_BITS-1:0]  dir_x_reg;
    logic signed [dsw_pkg::DIR_BITS-1:0]  dir_y_reg;
    logic signed [dsw_pkg::DIR_BITS-1:0]  dir_z_reg;
    logic signed [POSITION_BITS-1:0]      start_reg;
    logic signed [POSITION_BITS-1:0]      end_reg;
    logic [dsw_pkg::RECIP_BITS-1:0]       recip_reg;
    logic                                 cfg_write;

    dsw_pkg::q_status_t                   q_status;
    logic                                 push;
    logic                                 pop;
    logic [EW-1:0]                        push_data;
    logic [EW-1:0]                        pop_data;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg <= dsw_pkg::SPEED_RST;
            dir_x_reg <= dsw_pkg::DIR_X_RST;
            dir_y_reg <= dsw_pkg::DIR_Y_RST;
            dir_z_reg <= dsw_pkg::DIR_Z_RST;
            start_reg <= POSITION_BITS'(dsw_pkg::START_RST);
            end_reg   <= POSITION_BITS'(dsw_pkg::END_RST);
            recip_reg <= dsw_pkg::RECIP_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                dsw_pkg::REG_SPEED:        speed_reg <= cfg_data[dsw_pkg::SPEED_BITS-1:0];
                dsw_pkg::REG_DIR_X:        dir_x_reg <= cfg_data[dsw_pkg::DIR_BITS-1:0];
                dsw_pkg::REG_DIR_Y:        dir_y_reg <= cfg_data[dsw_pkg::DIR_BITS-1:0];
                dsw_pkg::REG_DIR_Z:        dir_z_reg <= cfg_data[dsw_pkg::DIR_BITS-1:0];
                dsw_pkg::REG_START:        start_reg <= cfg_data[POSITION_BITS-1:0];
                dsw_pkg::REG_END:          end_reg   <= cfg_data[POSITION_BITS-1:0];
                dsw_pkg::REG_WINDOW_RECIP: recip_reg <= cfg_data[dsw_pkg::RECIP_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    dsw_front #(
        .POSITION_BITS (POSITION_BITS),
        .COLOR_BITS    (COLOR_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .frame_delta (frame_delta),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .new_red     (new_red),
        .new_green   (new_green),
        .new_blue    (new_blue),
        .old_red     (old_red),
        .old_green   (old_green),
        .old_blue    (old_blue),
        .speed       (speed_reg),
        .dir_x       (dir_x_reg),
        .dir_y       (dir_y_reg),
        .dir_z       (dir_z_reg),
        .q_status    (q_status),
        .push        (push),
        .push_data   (push_data)
    );

    dsw_queue #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    dsw_back #(
        .POSITION_BITS (POSITION_BITS),
        .COLOR_BITS    (COLOR_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_status       (q_status),
        .pop            (pop),
        .pop_data       (pop_data),
        .start_position (start_reg),
        .end_position   (end_reg),
        .window_recip   (recip_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_red        (out_red),
        .out_green      (out_green),
        .out_blue       (out_blue),
        .wipe_done      (wipe_done),
        .tick_reply     (tick_reply)
    );

    // tick replies carry no colour
    `ASSERT_IMPLIES(a_tick_black, clk, rst_n, out_valid && tick_reply, out_red == '0 && out_green == '0 && out_blue == '0)
    // time saturates, so done never drops
    `ASSERT_NEXT(a_done_holds, clk, rst_n, wipe_done, wipe_done)
    // input stalls only on a full queue
    `ASSERT_IMPLIES(a_stall_full, clk, rst_n, in_stall, q_status.full)

endmodule
